>>> src/isq_pkg.sv
// Shared types and codes for the indexed sequence store.
`timescale 1ns / 1ps

package isq_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_INSERT     = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_POP_FRONT  = 3'd4,
      ACT_REMOVE     = 3'd5,
      ACT_READ       = 3'd6,
      ACT_CLEAR      = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic ins;
      logic rem;
   } op_type;

endpackage

>>> src/isq_cell.sv
// One storage cell of the entry chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module isq_cell #(
   parameter int ITEM_WIDTH = 32,
   parameter int POS_WIDTH  = 7,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  isq_pkg::op_type       op,
   input  logic [POS_WIDTH-1:0]  op_pos,
   input  logic [ITEM_WIDTH-1:0] op_value,
   input  logic [ITEM_WIDTH-1:0] left_data,
   input  logic [ITEM_WIDTH-1:0] right_data,
   output logic [ITEM_WIDTH-1:0] cell_data,
   output logic [ITEM_WIDTH-1:0] read_data
);
   import isq_pkg::*;

   localparam logic [POS_WIDTH-1:0] MyIndex = POS_WIDTH'(INDEX);

   logic [ITEM_WIDTH-1:0] data_ff;
   logic [ITEM_WIDTH-1:0] data_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (MyIndex == op_pos);
   assign above_pos = (MyIndex > op_pos);

   always_comb begin
      data_in = data_ff;
      if (op.ins) begin
         if (above_pos) begin
            data_in = left_data;
         end else if (at_pos) begin
            data_in = op_value;
         end
      end else if (op.rem) begin
         if (above_pos || at_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;
   assign read_data = at_pos ? data_ff : '0;

endmodule

>>> src/indexed_sequence_store_top.sv
// Top level of the indexed sequence store: request decode, cell chain and response register.
// Usage:
//   Request channel: drive req_action, req_position and req_item_value and raise start;
//   the transaction is taken at the rising edge where start is high and busy is low.
//   Response channel: rsp_valid is high for exactly one cycle, the cycle right after
//   the request was taken, with rsp_read_value, rsp_seq_length and rsp_status.
//   The receiver cannot stall; every response must be captured in its strobe cycle.
// Every action, including clear, gives its response through the same response register.
// Throughput: one transaction per cycle while busy is low, back to back. Positional insert
//   and remove need no sequence of shifts because every cell of the chain loads from its
//   left or right neighbor in parallel; reads select the addressed cell in the same cycle.
// Reset: synchronous, active high. Clears the entry count and the response strobe;
//   busy stays high for one cycle after reset is released. Entry contents are not
//   cleared; only entries below the count are ever returned.
// Clear empties the list by zeroing the count.
`timescale 1ns / 1ps

module indexed_sequence_store_top #(
   parameter int CAPACITY   = 64,
   parameter int ITEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_item_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_value,
   output logic [6:0]  rsp_seq_length,
   output logic [1:0]  rsp_status
);
   import isq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW : 7;
   localparam logic [PW-1:0] CapW = PW'(CAPACITY);

   logic                  busy_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_read_value_ff;
   logic [6:0]            rsp_seq_length_ff;
   status_type            rsp_status_ff;

   logic                  accept;
   action_type            action;
   logic [PW-1:0]         pos_w;
   logic [PW-1:0]         cnt_w;
   logic [PW-1:0]         target;
   logic                  is_put;
   logic                  is_take;
   logic                  is_read;
   status_type            status;
   op_type                op;
   logic [ITEM_WIDTH-1:0] value_w;
   logic [ITEM_WIDTH-1:0] rd_any;

   logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
   logic [ITEM_WIDTH-1:0] sel_data  [CAPACITY];

   assign accept  = start && !busy_ff;
   assign action  = action_type'(req_action);
   assign pos_w   = PW'(req_position);
   assign cnt_w   = PW'(count_ff);
   assign value_w = ITEM_WIDTH'(req_item_value);

   always_comb begin
      target  = pos_w;
      is_put  = 1'b0;
      is_take = 1'b0;
      is_read = 1'b0;
      case (action)
         ACT_PUSH_BACK: begin
            target = cnt_w;
            is_put = 1'b1;
         end
         ACT_PUSH_FRONT: begin
            target = '0;
            is_put = 1'b1;
         end
         ACT_INSERT: begin
            is_put = 1'b1;
         end
         ACT_POP_BACK: begin
            target  = cnt_w - PW'(1);
            is_take = 1'b1;
         end
         ACT_POP_FRONT: begin
            target  = '0;
            is_take = 1'b1;
         end
         ACT_REMOVE: begin
            is_take = 1'b1;
         end
         ACT_READ: begin
            is_read = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status = ST_OK;
      if (is_put) begin
         if (target > cnt_w) begin
            status = ST_RANGE;
         end else if (cnt_w >= CapW) begin
            status = ST_FULL;
         end
      end else if (is_take || is_read) begin
         if (count_ff == '0 || target >= cnt_w) begin
            status = ST_RANGE;
         end
      end
   end

   always_comb begin
      op.ins   = accept && is_put && (status == ST_OK);
      op.rem   = accept && is_take && (status == ST_OK);
      count_in = count_ff;
      if (accept) begin
         if (action == ACT_CLEAR) begin
            count_in = '0;
         end else if (op.ins) begin
            count_in = count_ff + CW'(1);
         end else if (op.rem) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_data;
      logic [ITEM_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      isq_cell #(
         .ITEM_WIDTH (ITEM_WIDTH),
         .POS_WIDTH  (PW),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .op_pos     (target),
         .op_value   (value_w),
         .left_data  (left_data),
         .right_data (right_data),
         .cell_data  (cell_data[i]),
         .read_data  (sel_data[i])
      );
   end

   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | sel_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= (is_read && status == ST_OK) ? 32'(rd_any) : '0;
         rsp_seq_length_ff <= 7'(count_in);
         rsp_status_ff     <= status;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_seq_length = rsp_seq_length_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      PW'(count_ff) <= CapW)
      else $error("entry count exceeds capacity");

   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response missing after accepted request");

   a_no_extra_rsp : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid_ff)
      else $error("response without request");

   a_full_at_cap : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (PW'(count_ff) == CapW))
      else $error("full status below capacity");

   a_read_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_read_value_ff == '0))
      else $error("read value on failed request");
`endif

endmodule
